// ----- sv/vqfm_pkg.sv -----
`timescale 1ns / 1ps

package vqfm_pkg;

	// Default sizes of the codebook.
	localparam int VECTOR_BYTES_DEF   = 16;
	localparam int CODEBOOK_DEPTH_DEF = 256;

	// Input command codes.
	localparam logic CMD_CODEBOOK = 1'b0;
	localparam logic CMD_BLOCK    = 1'b1;

	// Configuration register indexes.
	localparam int REG_IDX_W = 1;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_THRESHOLD = 1'b0;
	localparam reg_idx_t REG_ENTRIES   = 1'b1;

	// Search sequencer states.
	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

endpackage

// ----- sv/vqfm_cell.sv -----
`timescale 1ns / 1ps

module vqfm_cell #(
	parameter int VECTOR_BYTES   = 16,
	parameter int CODEBOOK_DEPTH = 256,
	parameter int LANE           = 0,
	parameter int ADDR_W         = $clog2(CODEBOOK_DEPTH),
	parameter int POS_W          = $clog2(VECTOR_BYTES),
	parameter int CNT_W          = $clog2(VECTOR_BYTES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cb_we,
	input  logic              blk_we,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [POS_W-1:0]  wr_pos,
	input  logic [7:0]        wr_byte,
	input  logic              flush,
	input  logic              in_valid,
	input  logic [ADDR_W-1:0] in_entry,
	input  logic [CNT_W-1:0]  in_count,
	output logic              out_valid,
	output logic [ADDR_W-1:0] out_entry,
	output logic [CNT_W-1:0]  out_count
);

	logic [7:0]        mem [CODEBOOK_DEPTH];
	logic [7:0]        rd_q;
	logic [7:0]        blk_q;
	logic              valid_q;
	logic [ADDR_W-1:0] entry_q;
	logic [CNT_W-1:0]  count_q;
	logic              lane_hit;

	assign lane_hit = (wr_pos == POS_W'(LANE));

	// Codebook lane: one byte of every entry, registered read.
	always_ff @(posedge clk) begin
		if (cb_we && lane_hit) begin
			mem[wr_addr] <= wr_byte;
		end
		rd_q <= mem[in_entry];
	end

	// Block byte held by this lane.
	always_ff @(posedge clk) begin
		if (blk_we && lane_hit) begin
			blk_q <= wr_byte;
		end
	end

	// Token from the previous cell: entry and partial count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid && !flush;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= in_entry;
		count_q <= in_count;
	end

	// Add this lane's mismatch and pass the token on.
	assign out_valid = valid_q;
	assign out_entry = entry_q;
	assign out_count = count_q + CNT_W'(rd_q != blk_q);

endmodule

// ----- sv/vqfm_ctrl.sv -----
`timescale 1ns / 1ps

module vqfm_ctrl #(
	parameter int ADDR_W = 8,
	parameter int ENT_W  = 9,
	parameter int CNT_W  = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [ENT_W-1:0]  limit,
	input  logic [CNT_W-1:0]  threshold,
	input  logic              tail_valid,
	input  logic [ADDR_W-1:0] tail_entry,
	input  logic [CNT_W-1:0]  tail_count,
	output logic              issue_valid,
	output logic [ADDR_W-1:0] issue_entry,
	output logic              flush,
	output logic              busy,
	output logic              done,
	output logic              match_found,
	output logic [ADDR_W-1:0] code_index
);

	import vqfm_pkg::*;

	state_t            state_q, state_d;
	logic [ENT_W-1:0]  issue_cnt_q;
	logic [ENT_W-1:0]  lim_q;
	logic [ENT_W-1:0]  last_q;
	logic              done_q;
	logic              match_q;
	logic [ADDR_W-1:0] code_q;
	logic              hit;
	logic              miss_end;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and search outputs.
	always_comb begin
		state_d     = state_q;
		issue_valid = 1'b0;
		hit         = 1'b0;
		miss_end    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (go && (limit != '0)) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				issue_valid = (issue_cnt_q < lim_q);
				hit         = tail_valid && (tail_count <= threshold);
				miss_end    = tail_valid && !hit && (ENT_W'(tail_entry) == last_q);
				if (hit || miss_end) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign flush       = hit || miss_end;
	assign issue_entry = issue_cnt_q[ADDR_W-1:0];
	assign busy        = (state_q != ST_IDLE);

	// Entry counter and search limit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_cnt_q <= '0;
			lim_q       <= '0;
			last_q      <= '0;
		end else if (state_q == ST_IDLE) begin
			issue_cnt_q <= '0;
			lim_q       <= limit;
			last_q      <= limit - 1'b1;
		end else if (issue_valid) begin
			issue_cnt_q <= issue_cnt_q + 1'b1;
		end
	end

	// Result register; the strobe lasts one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			match_q <= 1'b0;
			code_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if ((state_q == ST_IDLE) && go && (limit == '0)) begin
				done_q  <= 1'b1;
				match_q <= 1'b0;
				code_q  <= '0;
			end else if (hit) begin
				done_q  <= 1'b1;
				match_q <= 1'b1;
				code_q  <= tail_entry;
			end else if (miss_end) begin
				done_q  <= 1'b1;
				match_q <= 1'b0;
				code_q  <= '0;
			end
		end
	end

	assign done        = done_q;
	assign match_found = match_q;
	assign code_index  = code_q;

endmodule

// ----- sv/vq_first_match_hamming_encoder.sv -----
`timescale 1ns / 1ps
// A result follows the last block byte once the first matching entry has passed the chain of cells,
// or once the last entry in use has passed it on no match; zero entries give a result without a search.
// Throughput: one entry per cycle walks the chain of VECTOR_BYTES byte-lane cells.
// A codebook or block byte is taken with start while busy is low; no start is taken while busy is high.
// Reset clears the configuration and result registers and the sequencer; codebook and block bytes are undefined.
// The done strobe lasts one cycle and the receiver cannot stall it.

module vq_first_match_hamming_encoder #(
	parameter int VECTOR_BYTES   = vqfm_pkg::VECTOR_BYTES_DEF,
	parameter int CODEBOOK_DEPTH = vqfm_pkg::CODEBOOK_DEPTH_DEF,
	parameter int ADDR_W         = $clog2(CODEBOOK_DEPTH),
	parameter int POS_W          = $clog2(VECTOR_BYTES),
	parameter int CNT_W          = $clog2(VECTOR_BYTES + 1),
	parameter int ENT_W          = $clog2(CODEBOOK_DEPTH + 1),
	parameter int CFG_W          = (CNT_W > ENT_W) ? CNT_W : ENT_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  vqfm_pkg::reg_idx_t wr_index,
	input  logic [CFG_W-1:0]  wr_data,
	input  logic              start,
	output logic              busy,
	input  logic              command,
	input  logic [ADDR_W-1:0] entry_index,
	input  logic [POS_W-1:0]  byte_position,
	input  logic [7:0]        byte_value,
	output logic              done,
	output logic              match_found,
	output logic [ADDR_W-1:0] code_index
);

	import vqfm_pkg::*;

	logic [CNT_W-1:0]  thr_q;
	logic [ENT_W-1:0]  entries_q;
	logic [ENT_W-1:0]  limit;
	logic              accept;
	logic              pos_ok;
	logic              entry_ok;
	logic              cb_we;
	logic              blk_we;
	logic              go;
	logic              flush;
	logic              chain_valid [VECTOR_BYTES+1];
	logic [ADDR_W-1:0] chain_entry [VECTOR_BYTES+1];
	logic [CNT_W-1:0]  chain_count [VECTOR_BYTES+1];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= '0;
			entries_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_THRESHOLD: thr_q     <= wr_data[CNT_W-1:0];
				REG_ENTRIES:   entries_q <= wr_data[ENT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Entries beyond the codebook are not searched.
	assign limit = (entries_q > ENT_W'(CODEBOOK_DEPTH)) ? ENT_W'(CODEBOOK_DEPTH) : entries_q;

	// Input transfer decode.
	assign accept   = start && !busy;
	assign pos_ok   = ((POS_W + 1)'(byte_position) < (POS_W + 1)'(VECTOR_BYTES));
	assign entry_ok = ((ADDR_W + 1)'(entry_index) < (ADDR_W + 1)'(CODEBOOK_DEPTH));
	assign cb_we    = accept && pos_ok && entry_ok && (command == CMD_CODEBOOK);
	assign blk_we   = accept && pos_ok && (command == CMD_BLOCK);
	assign go       = blk_we && (byte_position == POS_W'(VECTOR_BYTES - 1));

	vqfm_ctrl #(
		.ADDR_W(ADDR_W),
		.ENT_W (ENT_W),
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.limit      (limit),
		.threshold  (thr_q),
		.tail_valid (chain_valid[VECTOR_BYTES]),
		.tail_entry (chain_entry[VECTOR_BYTES]),
		.tail_count (chain_count[VECTOR_BYTES]),
		.issue_valid(chain_valid[0]),
		.issue_entry(chain_entry[0]),
		.flush      (flush),
		.busy       (busy),
		.done       (done),
		.match_found(match_found),
		.code_index (code_index)
	);

	assign chain_count[0] = '0;

	// Chain of byte-lane cells; each adds its mismatch to the passing count.
	for (genvar g = 0; g < VECTOR_BYTES; g++) begin : g_cell
		vqfm_cell #(
			.VECTOR_BYTES  (VECTOR_BYTES),
			.CODEBOOK_DEPTH(CODEBOOK_DEPTH),
			.LANE          (g),
			.ADDR_W        (ADDR_W),
			.POS_W         (POS_W),
			.CNT_W         (CNT_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cb_we    (cb_we),
			.blk_we   (blk_we),
			.wr_addr  (entry_index),
			.wr_pos   (byte_position),
			.wr_byte  (byte_value),
			.flush    (flush),
			.in_valid (chain_valid[g]),
			.in_entry (chain_entry[g]),
			.in_count (chain_count[g]),
			.out_valid(chain_valid[g+1]),
			.out_entry(chain_entry[g+1]),
			.out_count(chain_count[g+1])
		);
	end

endmodule

// ----- tb/vq_code_checker.sv -----
`timescale 1ns / 1ps

module vq_code_checker #(
	parameter int VB    = vqfm_pkg::VECTOR_BYTES_DEF,
	parameter int DEPTH = vqfm_pkg::CODEBOOK_DEPTH_DEF,
	parameter int CFG_W = 9
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  vqfm_pkg::reg_idx_t wr_index,
	input  logic [CFG_W-1:0]   wr_data,
	input  logic               start,
	input  logic               busy,
	input  logic               command,
	input  logic [7:0]         entry_index,
	input  logic [3:0]         byte_position,
	input  logic [7:0]         byte_value,
	input  logic               done,
	input  logic               match_found,
	input  logic [7:0]         code_index,
	output int                 fail_count,
	output int                 pending,
	output int                 result_total,
	output int                 hit_total
);

	typedef struct packed {
		logic       found;
		logic [7:0] index;
	} search_code_t;

	// Mirror of the codebook, the block buffer and the two registers.
	logic [7:0] cb_mirror [DEPTH][VB];
	logic [7:0] block_mirror [VB];
	logic [4:0] thresh_q;
	logic [8:0] entries_q;

	search_code_t expected_codes[$];
	int fails;
	int results;
	int hits;

	assign fail_count   = fails;
	assign result_total = results;
	assign hit_total    = hits;

	// Walk the entries in use from zero and return the first one whose count of
	// differing bytes is within the threshold.
	function automatic search_code_t first_close_entry();
		search_code_t code;
		int limit;
		int diff;
		code = '0;
		limit = (entries_q > DEPTH) ? DEPTH : entries_q;
		for (int e = 0; e < limit; e++) begin
			diff = 0;
			for (int p = 0; p < VB; p++) begin
				if (block_mirror[p] != cb_mirror[e][p])
					diff++;
			end
			if (!code.found && diff <= thresh_q) begin
				code.found = 1'b1;
				code.index = e[7:0];
			end
		end
		return code;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		search_code_t want;
		if (!arst_n) begin
			thresh_q = '0;
			entries_q = '0;
			expected_codes.delete();
			fails = 0;
			results = 0;
			hits = 0;
			pending <= 0;
		end else begin
			// A result transfer is compared with the oldest expected code.
			if (done) begin
				results++;
				if (match_found === 1'b1)
					hits++;
				if (expected_codes.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: unexpected result found=%0b code=%0d", $realtime,
							match_found, code_index);
				end else begin
					want = expected_codes.pop_front();
					if (match_found !== want.found || code_index !== want.index) begin
						fails++;
						if (fails <= 10)
							$display("%0t: mismatch expected found=%0b code=%0d, got found=%0b code=%0d",
								$realtime, want.found, want.index, match_found, code_index);
					end
				end
			end

			// Register writes take effect at once.
			if (wr_en) begin
				if (wr_index == vqfm_pkg::REG_THRESHOLD)
					thresh_q = wr_data[4:0];
				else if (wr_index == vqfm_pkg::REG_ENTRIES)
					entries_q = wr_data[8:0];
			end

			// An input transfer updates the mirror; the last block byte starts a search.
			if (start && !busy && byte_position < VB) begin
				if (command == vqfm_pkg::CMD_CODEBOOK) begin
					if (entry_index < DEPTH)
						cb_mirror[entry_index][byte_position] = byte_value;
				end else begin
					block_mirror[byte_position] = byte_value;
					if (byte_position == VB - 1)
						expected_codes.push_back(first_close_entry());
				end
			end

			pending <= expected_codes.size();
		end
	end

endmodule

// ----- tb/tb_vq_first_match_hamming_encoder.sv -----
`timescale 1ns / 1ps

module tb_vq_first_match_hamming_encoder;

	localparam int VB           = vqfm_pkg::VECTOR_BYTES_DEF;
	localparam int DEPTH        = vqfm_pkg::CODEBOOK_DEPTH_DEF;
	localparam int CNT_W        = $clog2(VB + 1);
	localparam int ENT_W        = $clog2(DEPTH + 1);
	localparam int CFG_W        = (CNT_W > ENT_W) ? CNT_W : ENT_W;
	localparam int RANDOM_ITEMS = 1500;
	localparam int PHASE_ITEMS  = 120;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               wr_en = 1'b0;
	vqfm_pkg::reg_idx_t wr_index = vqfm_pkg::REG_THRESHOLD;
	logic [CFG_W-1:0]   wr_data = '0;
	logic               start = 1'b0;
	logic               busy;
	logic               command = vqfm_pkg::CMD_CODEBOOK;
	logic [7:0]         entry_index = '0;
	logic [3:0]         byte_position = '0;
	logic [7:0]         byte_value = '0;
	logic               done;
	logic               match_found;
	logic [7:0]         code_index;

	int fail_count;
	int pending;
	int result_total;
	int hit_total;

	// Stimulus-side image of the codebook, used to build blocks near an entry.
	logic [7:0] cb_image [DEPTH][VB];
	int thresh_cur;
	int entries_cur;
	int items_sent;
	int codebook_sent;
	int settings_used;
	bit steady;

	vq_first_match_hamming_encoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.entry_index  (entry_index),
		.byte_position(byte_position),
		.byte_value   (byte_value),
		.done         (done),
		.match_found  (match_found),
		.code_index   (code_index)
	);

	vq_code_checker #(
		.VB   (VB),
		.DEPTH(DEPTH),
		.CFG_W(CFG_W)
	) code_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.entry_index  (entry_index),
		.byte_position(byte_position),
		.byte_value   (byte_value),
		.done         (done),
		.match_found  (match_found),
		.code_index   (code_index),
		.fail_count   (fail_count),
		.pending      (pending),
		.result_total (result_total),
		.hit_total    (hit_total)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Hard limit on the run, several times the slowest correct run.
	initial begin
		#(20_000_000);
		$display("TEST FAILED");
		$finish;
	end

	// One input transfer after a random gap, unless the phase runs without gaps.
	task automatic send_byte(input logic cmd, input logic [7:0] entry, input logic [3:0] pos,
			input logic [7:0] val);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		entry_index <= entry;
		byte_position <= pos;
		byte_value <= val;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (cmd == vqfm_pkg::CMD_CODEBOOK) begin
			cb_image[entry][pos] = val;
			codebook_sent++;
		end
		items_sent++;
	endtask

	// Send positions up to the given one of a block that differs from an entry in
	// the given number of bytes, in sequence or scrambled with the last byte last.
	task automatic send_block(input int m, input int k, input bit scramble, input int upto);
		logic [7:0] vals [VB];
		int order [VB];
		int j;
		int tmp;
		logic [7:0] flip;
		for (int p = 0; p < VB; p++) begin
			vals[p] = cb_image[m][p];
			order[p] = p;
		end
		for (int p = VB - 1; p > 0; p--) begin
			j = $urandom_range(0, p);
			tmp = order[p];
			order[p] = order[j];
			order[j] = tmp;
		end
		for (int p = 0; p < k; p++) begin
			flip = 8'($urandom_range(1, 255));
			vals[order[p]] = vals[order[p]] ^ flip;
		end
		for (int p = 0; p < VB; p++)
			order[p] = p;
		if (scramble) begin
			for (int p = VB - 2; p > 0; p--) begin
				j = $urandom_range(0, p);
				tmp = order[p];
				order[p] = order[j];
				order[j] = tmp;
			end
		end
		for (int p = 0; p <= upto; p++)
			send_byte(vqfm_pkg::CMD_BLOCK, 8'($urandom_range(0, 255)), 4'(order[p]),
				vals[order[p]]);
	endtask

	// Hold off until every expected result has come and the block is idle.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Both registers are written back to back while the block is idle.
	task automatic write_config(input int th, input int ent);
		wr_en <= 1'b1;
		wr_index <= vqfm_pkg::REG_THRESHOLD;
		wr_data <= CFG_W'(th);
		@(posedge clk);
		wr_index <= vqfm_pkg::REG_ENTRIES;
		wr_data <= CFG_W'(ent);
		@(posedge clk);
		wr_en <= 1'b0;
		thresh_cur = th;
		entries_cur = ent;
		settings_used++;
	endtask

	initial begin
		int base;
		int phase_start;
		int kind;
		int m;
		int k;
		int r;
		int th;
		int ent;
		int searchable;

		items_sent = 0;
		codebook_sent = 0;
		settings_used = 0;
		thresh_cur = 0;
		entries_cur = 0;
		steady = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load the whole codebook: entry 0 all zeros, the last entry all ones.
		for (int e = 0; e < DEPTH; e++) begin
			steady = (e % 32) < 8;
			for (int p = 0; p < VB; p++) begin
				if (e == 0)
					send_byte(vqfm_pkg::CMD_CODEBOOK, 8'(e), 4'(p), 8'h00);
				else if (e == DEPTH - 1)
					send_byte(vqfm_pkg::CMD_CODEBOOK, 8'(e), 4'(p), 8'hFF);
				else
					send_byte(vqfm_pkg::CMD_CODEBOOK, 8'(e), 4'(p),
						8'($urandom_range(0, 255)));
			end
		end
		steady = 1'b0;
		drain();

		// Exact copy of the last entry: the search runs through the whole codebook.
		write_config(0, DEPTH);
		send_block(DEPTH - 1, 0, 1'b0, VB - 1);
		// Stale bytes: only the last position changes, leaving one differing byte.
		send_byte(vqfm_pkg::CMD_BLOCK, 8'h00, 4'(VB - 1), 8'h00);
		drain();
		write_config(1, DEPTH);
		send_byte(vqfm_pkg::CMD_BLOCK, 8'hFF, 4'(VB - 1), 8'h00);
		drain();
		// A threshold of the full vector length matches entry zero.
		write_config(VB, DEPTH);
		send_byte(vqfm_pkg::CMD_BLOCK, 8'h5A, 4'(VB - 1), 8'h00);
		drain();
		// No entries in use gives no match.
		write_config(VB, 0);
		send_byte(vqfm_pkg::CMD_BLOCK, 8'hA5, 4'(VB - 1), 8'h00);
		drain();
		// One entry, just below and at the distance of fifteen bytes.
		write_config(VB - 2, 1);
		send_byte(vqfm_pkg::CMD_BLOCK, 8'h00, 4'(VB - 1), 8'h00);
		drain();
		write_config(VB - 1, 1);
		send_byte(vqfm_pkg::CMD_BLOCK, 8'h00, 4'(VB - 1), 8'h00);
		drain();

		// Random part: mostly whole blocks near some entry, with codebook rewrites,
		// single block bytes and broken-off blocks mixed in. Settings include
		// thresholds above the vector length and entry counts above the codebook.
		base = items_sent;
		phase_start = -PHASE_ITEMS;
		while (items_sent - base < RANDOM_ITEMS) begin
			if (items_sent - phase_start >= PHASE_ITEMS) begin
				drain();
				r = $urandom_range(0, 9);
				th = (r < 4) ? $urandom_range(0, 3) :
					(r < 6) ? $urandom_range(VB, 31) : $urandom_range(0, VB);
				r = $urandom_range(0, 9);
				ent = (r < 2) ? DEPTH :
					(r == 2) ? $urandom_range(DEPTH + 1, (1 << ENT_W) - 1) :
					(r == 3) ? 0 : (r == 4) ? 1 : $urandom_range(2, DEPTH - 1);
				write_config(th, ent);
				steady = ($urandom_range(0, 3) == 0);
				phase_start = items_sent;
			end

			searchable = (entries_cur > DEPTH) ? DEPTH : entries_cur;
			if (searchable == 0 || $urandom_range(0, 9) == 0)
				m = $urandom_range(0, DEPTH - 1);
			else
				m = $urandom_range(0, searchable - 1);

			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				if ($urandom_range(0, 19) == 0)
					drain();
				r = $urandom_range(0, 9);
				if (r < 5)
					k = $urandom_range(0, (thresh_cur > VB) ? VB : thresh_cur);
				else if (r < 8)
					k = (thresh_cur + $urandom_range(1, 2) > VB) ? VB :
						thresh_cur + $urandom_range(1, 2);
				else
					k = $urandom_range(0, VB);
				send_block(m, k, $urandom_range(0, 4) == 0, VB - 1);
			end else if (kind < 85) begin
				repeat ($urandom_range(1, 4))
					send_byte(vqfm_pkg::CMD_CODEBOOK, 8'($urandom_range(0, DEPTH - 1)),
						4'($urandom_range(0, VB - 1)), 8'($urandom_range(0, 255)));
			end else if (kind < 95) begin
				send_byte(vqfm_pkg::CMD_BLOCK, 8'($urandom_range(0, 255)),
					4'($urandom_range(0, VB - 1)), 8'($urandom_range(0, 255)));
			end else begin
				send_block(m, $urandom_range(0, 3), 1'b0, $urandom_range(0, VB - 2));
			end
		end

		// Let the last search finish and watch for stray results.
		drain();
		repeat (VB + DEPTH + 16) @(posedge clk);

		$display("Covered %0d input transfers (%0d codebook loads) under %0d register settings.",
			items_sent, codebook_sent, settings_used);
		$display("Checked %0d search results, %0d of them with a matching entry.",
			result_total, hit_total);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
